### hw/rtl/c8ic_pkg.sv
// c8ic_pkg: shared types, codes and constants of the CHIP-8 instruction core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package c8ic_pkg;

    localparam int STACK_DEPTH_DEF   = 16;
    localparam int START_ADDRESS_DEF = 512;

    localparam int MEM_DEPTH  = 4096;
    localparam int SCR_BYTES  = 256;
    localparam int NUM_VREGS  = 16;
    localparam int FONT_LEN   = 80;
    localparam logic [11:0] FONT_BASE = 12'h050;
    localparam logic [11:0] MEM_LAST  = 12'hFFF;
    localparam logic [3:0]  VF_IDX    = 4'hF;

    localparam logic [7:0] FONT_ROM [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // transaction functions
    localparam logic [1:0] FN_EXEC  = 2'd0;
    localparam logic [1:0] FN_WRITE = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    // opcode groups (top nibble)
    localparam logic [3:0] OPG_SYS  = 4'h0;
    localparam logic [3:0] OPG_JP   = 4'h1;
    localparam logic [3:0] OPG_CALL = 4'h2;
    localparam logic [3:0] OPG_SEI  = 4'h3;
    localparam logic [3:0] OPG_SNEI = 4'h4;
    localparam logic [3:0] OPG_SER  = 4'h5;
    localparam logic [3:0] OPG_LDI  = 4'h6;
    localparam logic [3:0] OPG_ADDI = 4'h7;
    localparam logic [3:0] OPG_ALU  = 4'h8;
    localparam logic [3:0] OPG_SNER = 4'h9;
    localparam logic [3:0] OPG_LDIX = 4'hA;
    localparam logic [3:0] OPG_JPV0 = 4'hB;
    localparam logic [3:0] OPG_RND  = 4'hC;
    localparam logic [3:0] OPG_DRW  = 4'hD;
    localparam logic [3:0] OPG_KEY  = 4'hE;
    localparam logic [3:0] OPG_MISC = 4'hF;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] LO_CLS   = 8'hE0;
    localparam logic [7:0] LO_RET   = 8'hEE;
    localparam logic [7:0] LO_SKP   = 8'h9E;
    localparam logic [7:0] LO_SKNP  = 8'hA1;
    localparam logic [7:0] LO_GETDT = 8'h07;
    localparam logic [7:0] LO_WKEY  = 8'h0A;
    localparam logic [7:0] LO_SETDT = 8'h15;
    localparam logic [7:0] LO_SETST = 8'h18;
    localparam logic [7:0] LO_ADDI  = 8'h1E;
    localparam logic [7:0] LO_FONT  = 8'h29;
    localparam logic [7:0] LO_BCD   = 8'h33;
    localparam logic [7:0] LO_STORE = 8'h55;
    localparam logic [7:0] LO_LOAD  = 8'h65;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] addr;
        logic [7:0]  wdata;
        logic [15:0] keys;
        logic [7:0]  rand_byte;
    } req_t;

    typedef struct packed {
        logic [11:0] pc_now;
        logic [15:0] opcode_seen;
        logic        draw;
        logic        waiting_key;
        logic        unknown_op;
        logic        sound_on;
        logic [7:0]  pixels;
    } rsp_t;

    typedef enum logic [4:0] {
        CS_CLEAR, CS_IDLE, CS_DISPATCH, CS_FETCH1, CS_FETCH2, CS_EXEC,
        CS_BCD, CS_ST_RD, CS_ST_WR, CS_LD_RD, CS_LD_WR,
        CS_DR_ROW, CS_DR_RDA, CS_DR_RDB, CS_DR_WRA, CS_DR_WRB,
        CS_FLAG, CS_RESULT
    } ctl_state_t;

    typedef enum logic [4:0] {
        DP_NONE, DP_CLEAR, DP_ACCEPT, DP_DISPATCH, DP_FETCH1, DP_FETCH2, DP_EXEC,
        DP_BCD_WR, DP_ST_RD, DP_ST_WR, DP_LD_RD, DP_LD_WR,
        DP_DR_ROW, DP_DR_RDA, DP_DR_RDB, DP_DR_WRA, DP_DR_WRB,
        DP_FLAG, DP_RESULT
    } dp_op_t;

    typedef enum logic [2:0] {
        EK_SIMPLE, EK_FLAG, EK_DRAW, EK_BCD, EK_STORE, EK_LOAD
    } exec_kind_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] idx;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        exec_kind_t kind;
        logic [3:0] n;
        logic [3:0] x;
        logic       clr_done;
        logic       rsp_free;
    } dp_status_t;

endpackage

### hw/rtl/c8ic_ctrl.sv
// c8ic_ctrl: sequencing state machine of the CHIP-8 core.
// Depends on c8ic_pkg; drives datapath commands, reads datapath status.
`timescale 1ns / 1ps

module c8ic_ctrl
    import c8ic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  dp_status_t status,
    output logic       req_stall,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            CS_CLEAR:
            begin
                if (status.clr_done)
                    state_next = CS_IDLE;
            end
            CS_IDLE:
            begin
                if (req_valid)
                    state_next = CS_DISPATCH;
            end
            CS_DISPATCH:
            begin
                state_next = (status.func == FN_EXEC) ? CS_FETCH1 : CS_RESULT;
            end
            CS_FETCH1: state_next = CS_FETCH2;
            CS_FETCH2: state_next = CS_EXEC;
            CS_EXEC:
            begin
                cnt_next = '0;
                case (status.kind)
                    EK_FLAG:  state_next = CS_FLAG;
                    EK_DRAW:  state_next = (status.n == 4'd0) ? CS_FLAG : CS_DR_ROW;
                    EK_BCD:   state_next = CS_BCD;
                    EK_STORE: state_next = CS_ST_RD;
                    EK_LOAD:  state_next = CS_LD_RD;
                    default:  state_next = CS_RESULT;
                endcase
            end
            CS_BCD:
            begin
                if (cnt_reg == 4'd2)
                    state_next = CS_RESULT;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            CS_ST_RD: state_next = CS_ST_WR;
            CS_ST_WR:
            begin
                if (cnt_reg == status.x)
                    state_next = CS_RESULT;
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = CS_ST_RD;
                end
            end
            CS_LD_RD: state_next = CS_LD_WR;
            CS_LD_WR:
            begin
                if (cnt_reg == status.x)
                    state_next = CS_RESULT;
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = CS_LD_RD;
                end
            end
            CS_DR_ROW: state_next = CS_DR_RDA;
            CS_DR_RDA: state_next = CS_DR_RDB;
            CS_DR_RDB: state_next = CS_DR_WRA;
            CS_DR_WRA: state_next = CS_DR_WRB;
            CS_DR_WRB:
            begin
                if ((cnt_reg + 4'd1) == status.n)
                    state_next = CS_FLAG;
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = CS_DR_ROW;
                end
            end
            CS_FLAG: state_next = CS_RESULT;
            CS_RESULT:
            begin
                if (status.rsp_free)
                    state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.idx   = cnt_reg;
        cmd.last  = (cnt_reg == status.x);
        req_stall = (state_reg != CS_IDLE);
        case (state_reg)
            CS_CLEAR:    cmd.op = DP_CLEAR;
            CS_IDLE:     cmd.op = req_valid ? DP_ACCEPT : DP_NONE;
            CS_DISPATCH: cmd.op = DP_DISPATCH;
            CS_FETCH1:   cmd.op = DP_FETCH1;
            CS_FETCH2:   cmd.op = DP_FETCH2;
            CS_EXEC:     cmd.op = DP_EXEC;
            CS_BCD:      cmd.op = DP_BCD_WR;
            CS_ST_RD:    cmd.op = DP_ST_RD;
            CS_ST_WR:    cmd.op = DP_ST_WR;
            CS_LD_RD:    cmd.op = DP_LD_RD;
            CS_LD_WR:    cmd.op = DP_LD_WR;
            CS_DR_ROW:   cmd.op = DP_DR_ROW;
            CS_DR_RDA:   cmd.op = DP_DR_RDA;
            CS_DR_RDB:   cmd.op = DP_DR_RDB;
            CS_DR_WRA:   cmd.op = DP_DR_WRA;
            CS_DR_WRB:   cmd.op = DP_DR_WRB;
            CS_FLAG:     cmd.op = DP_FLAG;
            CS_RESULT:   cmd.op = DP_RESULT;
            default:     cmd.op = DP_NONE;
        endcase
    end

endmodule

### hw/rtl/c8ic_datapath.sv
// c8ic_datapath: memories, registers, decode and result register of the core.
// Depends on c8ic_pkg; commanded by c8ic_ctrl.
`timescale 1ns / 1ps

module c8ic_datapath
    import c8ic_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int START_ADDRESS = START_ADDRESS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  req_t       req,
    input  logic       rsp_stall,
    output dp_status_t status,
    output logic       rsp_valid,
    output rsp_t       rsp
);

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);
    localparam logic [11:0] PC_START = 12'(START_ADDRESS);

    // storage
    logic [7:0] main_mem [MEM_DEPTH];
    logic [7:0] scr_mem  [SCR_BYTES];
    logic [7:0] vreg_mem [NUM_VREGS];
    logic [7:0] mem_q_reg, scr_q_reg, va_q_reg, vb_q_reg;
    logic [SCR_BYTES-1:0] scr_vld_reg, scr_vld_next;
    logic [NUM_VREGS-1:0] vreg_vld_reg, vreg_vld_next;

    // memory port controls
    logic        mem_we, mem_re;
    logic [11:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic        scr_we, scr_re;
    logic [7:0]  scr_addr, scr_wdata;
    logic        v_we, v_re;
    logic [3:0]  v_waddr, v_ra, v_rb;
    logic [7:0]  v_wdata;
    logic        stk_we;

    // architectural and working registers
    req_t        item_reg, item_next;
    logic [7:0]  hi_reg, hi_next, lo_reg, lo_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] i_reg, i_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [7:0]  delay_reg, delay_next, sound_reg, sound_next;
    logic        flag_reg, flag_next;
    logic        draw_reg, draw_next, wait_reg, wait_next, unk_reg, unk_next;
    logic [3:0]  d2_reg, d2_next, d1_reg, d1_next, d0_reg, d0_next;
    logic [15:0] spr_reg, spr_next;
    logic [7:0]  scr_a_reg, scr_a_next;
    logic [11:0] clr_cnt_reg, clr_cnt_next;
    logic        clr_done_reg, clr_done_next;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg, rsp_valid_next;

    // decode fields
    logic [3:0]  nib, fx, fy, fn;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [7:0]  vx, vy;
    logic [11:0] pc2, pc4;
    logic [SP_W-1:0] sp_inc, sp_dec;
    logic [15:0] i_idx, i_after;
    logic [16:0] i_sum;
    logic [8:0]  add_sum;
    logic [1:0]  bcd_h;
    logic [6:0]  bcd_r;
    logic [14:0] bcd_m;
    logic [3:0]  bcd_t;
    logic [6:0]  bcd_t10;
    logic [3:0]  hkey;
    logic        kdown;
    logic [4:0]  scr_row;
    logic [2:0]  col_a, col_b;
    logic [11:0] clr_off;
    logic        rsp_free;
    exec_kind_t  kind;

    assign nib = hi_reg[7:4];
    assign fx  = hi_reg[3:0];
    assign fy  = lo_reg[7:4];
    assign fn  = lo_reg[3:0];
    assign nn  = lo_reg;
    assign nnn = {hi_reg[3:0], lo_reg};
    assign vx  = va_q_reg;
    assign vy  = vb_q_reg;
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    assign sp_inc = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;
    assign i_idx   = i_reg + {12'd0, cmd.idx};
    assign i_after = i_reg + {12'd0, fx} + 16'd1;
    assign i_sum   = {1'b0, i_reg} + {9'd0, vx};
    assign add_sum = {1'b0, vx} + {1'b0, vy};
    assign kdown   = (vx[7:4] == 4'd0) && item_reg.keys[vx[3:0]];
    assign scr_row = vy_reg[4:0] + {1'b0, cmd.idx};
    assign col_a   = vx_reg[5:3];
    assign col_b   = col_a + 3'd1;
    assign clr_off = clr_cnt_reg - FONT_BASE;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // decimal digits by compare and reciprocal multiply
    assign bcd_h   = (vx >= 8'd200) ? 2'd2 : ((vx >= 8'd100) ? 2'd1 : 2'd0);
    assign bcd_r   = 7'(vx - 8'(bcd_h) * 8'd100);
    assign bcd_m   = 15'(bcd_r) * 15'd205;
    assign bcd_t   = bcd_m[14:11];
    assign bcd_t10 = 7'(bcd_t) * 7'd10;

    always_comb
    begin
        hkey = '0;
        for (int k = 0; k < 16; k++)
            if (item_reg.keys[k])
                hkey = 4'(k);
    end

    always_comb
    begin
        kind = EK_SIMPLE;
        case (nib)
            OPG_ALU:
            begin
                if (fn == ALU_ADD || fn == ALU_SUB || fn == ALU_SHR ||
                    fn == ALU_SBN || fn == ALU_SHL)
                    kind = EK_FLAG;
            end
            OPG_DRW: kind = EK_DRAW;
            OPG_MISC:
            begin
                case (nn)
                    LO_ADDI:  kind = EK_FLAG;
                    LO_BCD:   kind = EK_BCD;
                    LO_STORE: kind = EK_STORE;
                    LO_LOAD:  kind = EK_LOAD;
                    default:  kind = EK_SIMPLE;
                endcase
            end
            default: kind = EK_SIMPLE;
        endcase
    end

    assign status.func     = item_reg.func;
    assign status.kind     = kind;
    assign status.n        = fn;
    assign status.x        = fx;
    assign status.clr_done = clr_done_reg;
    assign status.rsp_free = rsp_free;

    always_comb
    begin
        item_next      = item_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        pc_next        = pc_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        delay_next     = delay_reg;
        sound_next     = sound_reg;
        flag_next      = flag_reg;
        draw_next      = draw_reg;
        wait_next      = wait_reg;
        unk_next       = unk_reg;
        d2_next        = d2_reg;
        d1_next        = d1_reg;
        d0_next        = d0_reg;
        spr_next       = spr_reg;
        scr_a_next     = scr_a_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_done_next  = clr_done_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        scr_vld_next   = scr_vld_reg;
        vreg_vld_next  = vreg_vld_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = pc_reg;
        mem_wdata = 8'd0;
        scr_we    = 1'b0;
        scr_re    = 1'b0;
        scr_addr  = {scr_row, col_a};
        scr_wdata = 8'd0;
        v_we      = 1'b0;
        v_re      = 1'b0;
        v_waddr   = fx;
        v_wdata   = 8'd0;
        v_ra      = fx;
        v_rb      = fy;
        stk_we    = 1'b0;

        case (cmd.op)
            DP_CLEAR:
            begin
                if (!clr_done_reg)
                begin
                    mem_we   = 1'b1;
                    mem_addr = clr_cnt_reg;
                    if (clr_cnt_reg >= FONT_BASE &&
                        clr_cnt_reg < FONT_BASE + 12'(FONT_LEN))
                        mem_wdata = FONT_ROM[clr_off[6:0]];
                    clr_cnt_next = clr_cnt_reg + 12'd1;
                    if (clr_cnt_reg == MEM_LAST)
                        clr_done_next = 1'b1;
                end
            end
            DP_ACCEPT: item_next = req;
            DP_DISPATCH:
            begin
                draw_next = 1'b0;
                wait_next = 1'b0;
                unk_next  = 1'b0;
                case (item_reg.func)
                    FN_WRITE:
                    begin
                        mem_we    = 1'b1;
                        mem_addr  = item_reg.addr;
                        mem_wdata = item_reg.wdata;
                    end
                    FN_TICK:
                    begin
                        if (sound_reg != 8'd0) sound_next = sound_reg - 8'd1;
                        if (delay_reg != 8'd0) delay_next = delay_reg - 8'd1;
                    end
                    FN_READ:
                    begin
                        scr_re   = 1'b1;
                        scr_addr = item_reg.addr[7:0];
                    end
                    default:
                    begin
                        mem_re   = 1'b1;
                        mem_addr = pc_reg;
                    end
                endcase
            end
            DP_FETCH1:
            begin
                hi_next  = mem_q_reg;
                mem_re   = 1'b1;
                mem_addr = pc_reg + 12'd1;
            end
            DP_FETCH2:
            begin
                lo_next = mem_q_reg;
                v_re    = 1'b1;
                v_ra    = (hi_reg[7:4] == OPG_JPV0) ? 4'd0 : hi_reg[3:0];
                v_rb    = mem_q_reg[7:4];
            end
            DP_EXEC:
            begin
                vx_next   = vx;
                vy_next   = vy;
                pc_next   = pc2;
                flag_next = 1'b0;
                d2_next   = {2'd0, bcd_h};
                d1_next   = bcd_t;
                d0_next   = 4'(bcd_r - bcd_t10);
                case (nib)
                    OPG_SYS:
                    begin
                        if (nn == LO_CLS)
                        begin
                            scr_vld_next = '0;
                            draw_next    = 1'b1;
                        end
                        else if (nn == LO_RET)
                        begin
                            sp_next = sp_dec;
                            pc_next = stack_reg[sp_dec] + 12'd2;
                        end
                        else
                            unk_next = 1'b1;
                    end
                    OPG_JP: pc_next = nnn;
                    OPG_CALL:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = nnn;
                    end
                    OPG_SEI:  if (vx == nn) pc_next = pc4;
                    OPG_SNEI: if (vx != nn) pc_next = pc4;
                    OPG_SER:  if (vx == vy) pc_next = pc4;
                    OPG_SNER: if (vx != vy) pc_next = pc4;
                    OPG_LDI:
                    begin
                        v_we    = 1'b1;
                        v_wdata = nn;
                    end
                    OPG_ADDI:
                    begin
                        v_we    = 1'b1;
                        v_wdata = vx + nn;
                    end
                    OPG_ALU:
                    begin
                        v_we = 1'b1;
                        case (fn)
                            ALU_MOV: v_wdata = vy;
                            ALU_OR:  v_wdata = vx | vy;
                            ALU_AND: v_wdata = vx & vy;
                            ALU_XOR: v_wdata = vx ^ vy;
                            ALU_ADD:
                            begin
                                v_wdata   = add_sum[7:0];
                                flag_next = add_sum[8];
                            end
                            ALU_SUB:
                            begin
                                v_wdata   = vx - vy;
                                flag_next = (vx >= vy);
                            end
                            ALU_SHR:
                            begin
                                v_wdata   = {1'b0, vx[7:1]};
                                flag_next = vx[0];
                            end
                            ALU_SBN:
                            begin
                                v_wdata   = vy - vx;
                                flag_next = (vy >= vx);
                            end
                            ALU_SHL:
                            begin
                                v_wdata   = {vx[6:0], 1'b0};
                                flag_next = vx[7];
                            end
                            default:
                            begin
                                v_we     = 1'b0;
                                unk_next = 1'b1;
                            end
                        endcase
                    end
                    OPG_LDIX: i_next = {4'd0, nnn};
                    OPG_JPV0: pc_next = {4'd0, vx} + nnn;
                    OPG_RND:
                    begin
                        v_we    = 1'b1;
                        v_wdata = item_reg.rand_byte & nn;
                    end
                    OPG_DRW: draw_next = 1'b1;
                    OPG_KEY:
                    begin
                        if (nn == LO_SKP)
                        begin
                            if (kdown) pc_next = pc4;
                        end
                        else if (nn == LO_SKNP)
                        begin
                            if (!kdown) pc_next = pc4;
                        end
                        else
                            unk_next = 1'b1;
                    end
                    default:
                    begin
                        case (nn)
                            LO_GETDT:
                            begin
                                v_we    = 1'b1;
                                v_wdata = delay_reg;
                            end
                            LO_WKEY:
                            begin
                                if (item_reg.keys != 16'd0)
                                begin
                                    v_we    = 1'b1;
                                    v_wdata = {4'd0, hkey};
                                end
                                else
                                begin
                                    pc_next   = pc_reg;
                                    wait_next = 1'b1;
                                end
                            end
                            LO_SETDT: delay_next = vx;
                            LO_SETST: sound_next = vx;
                            LO_ADDI:
                            begin
                                i_next    = i_sum[15:0];
                                flag_next = (i_sum > 17'h00FFF);
                            end
                            LO_FONT:
                                i_next = {4'd0, FONT_BASE} +
                                         {6'd0, vx, 2'd0} + {8'd0, vx};
                            LO_BCD, LO_STORE, LO_LOAD: ;
                            default: unk_next = 1'b1;
                        endcase
                    end
                endcase
            end
            DP_BCD_WR:
            begin
                mem_we   = 1'b1;
                mem_addr = i_idx[11:0];
                case (cmd.idx[1:0])
                    2'd0:    mem_wdata = {4'd0, d2_reg};
                    2'd1:    mem_wdata = {4'd0, d1_reg};
                    default: mem_wdata = {4'd0, d0_reg};
                endcase
            end
            DP_ST_RD:
            begin
                v_re = 1'b1;
                v_ra = cmd.idx;
            end
            DP_ST_WR:
            begin
                mem_we    = 1'b1;
                mem_addr  = i_idx[11:0];
                mem_wdata = va_q_reg;
                if (cmd.last) i_next = i_after;
            end
            DP_LD_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = i_idx[11:0];
            end
            DP_LD_WR:
            begin
                v_we    = 1'b1;
                v_waddr = cmd.idx;
                v_wdata = mem_q_reg;
                if (cmd.last) i_next = i_after;
            end
            DP_DR_ROW:
            begin
                mem_re   = 1'b1;
                mem_addr = i_idx[11:0];
            end
            DP_DR_RDA:
            begin
                spr_next = {mem_q_reg, 8'd0} >> vx_reg[2:0];
                scr_re   = 1'b1;
                scr_addr = {scr_row, col_a};
            end
            DP_DR_RDB:
            begin
                scr_a_next = scr_q_reg;
                scr_re     = 1'b1;
                scr_addr   = {scr_row, col_b};
            end
            DP_DR_WRA:
            begin
                scr_we    = 1'b1;
                scr_addr  = {scr_row, col_a};
                scr_wdata = scr_a_reg ^ spr_reg[15:8];
                flag_next = flag_reg | (|(scr_a_reg & spr_reg[15:8]));
            end
            DP_DR_WRB:
            begin
                scr_we    = 1'b1;
                scr_addr  = {scr_row, col_b};
                scr_wdata = scr_q_reg ^ spr_reg[7:0];
                flag_next = flag_reg | (|(scr_q_reg & spr_reg[7:0]));
            end
            DP_FLAG:
            begin
                v_we    = 1'b1;
                v_waddr = VF_IDX;
                v_wdata = {7'd0, flag_reg};
            end
            DP_RESULT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.pc_now      = pc_reg;
                    rsp_next.opcode_seen = (item_reg.func == FN_EXEC) ?
                                           {hi_reg, lo_reg} : 16'd0;
                    rsp_next.draw        = draw_reg;
                    rsp_next.waiting_key = wait_reg;
                    rsp_next.unknown_op  = unk_reg;
                    rsp_next.sound_on    = (sound_reg != 8'd0);
                    rsp_next.pixels      = (item_reg.func == FN_READ) ?
                                           scr_q_reg : 8'd0;
                end
            end
            default: ;
        endcase

        if (scr_we) scr_vld_next[scr_addr] = 1'b1;
        if (v_we)   vreg_vld_next[v_waddr] = 1'b1;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
            main_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= main_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[scr_addr] <= scr_wdata;
        if (scr_re)
            scr_q_reg <= scr_vld_reg[scr_addr] ? scr_mem[scr_addr] : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vreg_mem[v_waddr] <= v_wdata;
        if (v_re)
        begin
            va_q_reg <= vreg_vld_reg[v_ra] ? vreg_mem[v_ra] : 8'd0;
            vb_q_reg <= vreg_vld_reg[v_rb] ? vreg_mem[v_rb] : 8'd0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        flag_reg  <= flag_next;
        d2_reg    <= d2_next;
        d1_reg    <= d1_next;
        d0_reg    <= d0_next;
        spr_reg   <= spr_next;
        scr_a_reg <= scr_a_next;
        rsp_reg   <= rsp_next;
    end

    // architectural and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_START;
            i_reg         <= '0;
            sp_reg        <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
            draw_reg      <= 1'b0;
            wait_reg      <= 1'b0;
            unk_reg       <= 1'b0;
            clr_cnt_reg   <= '0;
            clr_done_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            scr_vld_reg   <= '0;
            vreg_vld_reg  <= '0;
            for (int s = 0; s < STACK_DEPTH; s++)
                stack_reg[s] <= '0;
        end
        else
        begin
            pc_reg        <= pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            draw_reg      <= draw_next;
            wait_reg      <= wait_next;
            unk_reg       <= unk_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_done_reg  <= clr_done_next;
            rsp_valid_reg <= rsp_valid_next;
            scr_vld_reg   <= scr_vld_next;
            vreg_vld_reg  <= vreg_vld_next;
            if (stk_we)
                stack_reg[sp_reg] <= pc_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/chip8_instruction_core.sv
// chip8_instruction_core: top level of the CHIP-8 core, controller plus datapath.
// Depends on c8ic_pkg, c8ic_ctrl and c8ic_datapath.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req (req_t)
//   rsp     | out       | rsp_valid / rsp_stall | rsp (rsp_t)
//
// One transaction at a time. Memory write, timer tick and display read go from
// dispatch straight to the result. Execute reads the two opcode bytes from the
// single-port main memory, one access per cycle; a VF update, each DXYN row, each
// FX55/FX65 register and each FX33 digit add states. After reset a pass over every
// address loads the font and zeroes memory; req_stall stays high until it ends. A
// stalled result sits in the output register while the next transaction is taken.
`timescale 1ns / 1ps

module chip8_instruction_core
    import c8ic_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int START_ADDRESS = START_ADDRESS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    dp_cmd_t    cmd;
    dp_status_t status;

    c8ic_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    c8ic_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .START_ADDRESS (START_ADDRESS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_ACCEPT |=> cmd.op == DP_DISPATCH)
        else $error("accepted transaction not dispatched");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_RESULT && status.rsp_free) |=> rsp_valid)
        else $error("result not loaded into output register");

    a_taken_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && cmd.op != DP_RESULT) |=> !rsp_valid)
        else $error("taken result still shown");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !status.clr_done |-> cmd.op == DP_CLEAR || cmd.op == DP_NONE)
        else $error("work started before memory initialisation ended");

endmodule

### tb/sv/chip8_instruction_core_tb.sv
// chip8_instruction_core_tb: self-checking bench for the CHIP-8 instruction core.
// Depends on c8ic_pkg and chip8_instruction_core; an in-bench CHIP-8 model predicts
// each result that the directed rows do not give, with random stall and idle on both channels.
`timescale 1ns / 1ps

module chip8_instruction_core_tb;
    import c8ic_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    chip8_instruction_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t e;
    } stim_row_t;

    // machine state mirrored by the bench
    logic [7:0]  mem [MEM_DEPTH];
    logic        scr [2048];
    logic [7:0]  v [NUM_VREGS];
    logic [15:0] ireg;
    logic [11:0] cur_pc;
    logic [11:0] ret_stack [16];
    logic [3:0]  sp;
    logic [7:0]  delay_t;
    logic [7:0]  sound_t;

    rsp_t      pending_results [$];
    stim_row_t dir_rows [$];

    int mismatches;
    int sent;
    int n_exec, n_draw, n_wait, n_unknown, n_checked;
    int tx_pct, rx_pct;
    bit hold_go, hold_seen;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic void reset_model();
        for (int a = 0; a < MEM_DEPTH; a++)
            mem[a] = 8'h00;
        for (int a = 0; a < FONT_LEN; a++)
            mem[FONT_BASE + a] = FONT_ROM[a];
        for (int a = 0; a < 2048; a++)
            scr[a] = 1'b0;
        for (int a = 0; a < 16; a++)
        begin
            v[a] = 8'h00;
            ret_stack[a] = 12'h000;
        end
        ireg = 16'h0000;
        cur_pc = 12'(START_ADDRESS_DEF);
        sp = 4'd0;
        delay_t = 8'h00;
        sound_t = 8'h00;
    endfunction

    function automatic rsp_t chip8_step(req_t r);
        rsp_t o;
        logic [11:0] pcw, nxt, skp, pc_new;
        logic [15:0] word;
        logic [3:0] x, y, n;
        logic [7:0] nn, vx, vy, row;
        int base, p, s;
        bit hit, any;
        o = '0;
        case (r.func)
            FN_WRITE: mem[r.addr] = r.wdata;
            FN_TICK:
            begin
                if (sound_t != 0) sound_t--;
                if (delay_t != 0) delay_t--;
            end
            FN_READ:
            begin
                base = r.addr[7:3] * 64 + r.addr[2:0] * 8;
                for (int j = 0; j < 8; j++)
                    o.pixels[7 - j] = scr[base + j];
            end
            default:
            begin
                pcw = cur_pc;
                nxt = pcw + 12'd2;
                skp = pcw + 12'd4;
                word = {mem[pcw], mem[pcw + 12'd1]};
                x = word[11:8];
                y = word[7:4];
                n = word[3:0];
                nn = word[7:0];
                vx = v[x];
                vy = v[y];
                pc_new = nxt;
                case (word[15:12])
                    OPG_SYS:
                        if (nn == LO_CLS)
                        begin
                            for (int a = 0; a < 2048; a++)
                                scr[a] = 1'b0;
                            o.draw = 1'b1;
                        end
                        else if (nn == LO_RET)
                        begin
                            sp = sp - 4'd1;
                            pc_new = ret_stack[sp] + 12'd2;
                        end
                        else
                            o.unknown_op = 1'b1;
                    OPG_JP:   pc_new = word[11:0];
                    OPG_CALL:
                    begin
                        ret_stack[sp] = pcw;
                        sp = sp + 4'd1;
                        pc_new = word[11:0];
                    end
                    OPG_SEI:  if (vx == nn) pc_new = skp;
                    OPG_SNEI: if (vx != nn) pc_new = skp;
                    OPG_SER:  if (vx == vy) pc_new = skp;
                    OPG_LDI:  v[x] = nn;
                    OPG_ADDI: v[x] = vx + nn;
                    OPG_ALU:
                        case (n)
                            ALU_MOV: v[x] = vy;
                            ALU_OR:  v[x] = vx | vy;
                            ALU_AND: v[x] = vx & vy;
                            ALU_XOR: v[x] = vx ^ vy;
                            ALU_ADD:
                            begin
                                v[x] = vx + vy;
                                v[VF_IDX] = {7'd0, (({1'b0, vx} + {1'b0, vy}) > 9'h0FF)};
                            end
                            ALU_SUB:
                            begin
                                v[x] = vx - vy;
                                v[VF_IDX] = {7'd0, (vx >= vy)};
                            end
                            ALU_SHR:
                            begin
                                v[x] = vx >> 1;
                                v[VF_IDX] = {7'd0, vx[0]};
                            end
                            ALU_SBN:
                            begin
                                v[x] = vy - vx;
                                v[VF_IDX] = {7'd0, (vy >= vx)};
                            end
                            ALU_SHL:
                            begin
                                v[x] = vx << 1;
                                v[VF_IDX] = {7'd0, vx[7]};
                            end
                            default: o.unknown_op = 1'b1;
                        endcase
                    OPG_SNER: if (vx != vy) pc_new = skp;
                    OPG_LDIX: ireg = {4'h0, word[11:0]};
                    OPG_JPV0: pc_new = {4'h0, v[0]} + word[11:0];
                    OPG_RND:  v[x] = r.rand_byte & nn;
                    OPG_DRW:
                    begin
                        hit = 1'b0;
                        for (int i = 0; i < n; i++)
                        begin
                            row = mem[ireg[11:0] + i[11:0]];
                            for (int j = 0; j < 8; j++)
                                if (row[7 - j])
                                begin
                                    p = ((vy + i) % 32) * 64 + (vx + j) % 64;
                                    if (scr[p]) hit = 1'b1;
                                    scr[p] = ~scr[p];
                                end
                        end
                        v[VF_IDX] = {7'd0, hit};
                        o.draw = 1'b1;
                    end
                    OPG_KEY:
                        if (nn == LO_SKP)
                        begin
                            if (vx < 16 && r.keys[vx[3:0]]) pc_new = skp;
                        end
                        else if (nn == LO_SKNP)
                        begin
                            if (!(vx < 16 && r.keys[vx[3:0]])) pc_new = skp;
                        end
                        else
                            o.unknown_op = 1'b1;
                    default:
                        case (nn)
                            LO_GETDT: v[x] = delay_t;
                            LO_WKEY:
                            begin
                                any = 1'b0;
                                for (int k = 0; k < 16; k++)
                                    if (r.keys[k])
                                    begin
                                        v[x] = 8'(k);
                                        any = 1'b1;
                                    end
                                if (!any)
                                begin
                                    pc_new = pcw;
                                    o.waiting_key = 1'b1;
                                end
                            end
                            LO_SETDT: delay_t = vx;
                            LO_SETST: sound_t = vx;
                            LO_ADDI:
                            begin
                                s = ireg + vx;
                                ireg = s[15:0];
                                v[VF_IDX] = {7'd0, (s > 'hFFF)};
                            end
                            LO_FONT: ireg = 16'(FONT_BASE + vx * 5);
                            LO_BCD:
                            begin
                                mem[ireg[11:0]] = 8'(vx / 100);
                                mem[ireg[11:0] + 12'd1] = 8'((vx / 10) % 10);
                                mem[ireg[11:0] + 12'd2] = 8'(vx % 10);
                            end
                            LO_STORE:
                            begin
                                for (int i = 0; i <= x; i++)
                                    mem[ireg[11:0] + i[11:0]] = v[i];
                                ireg = ireg + x + 16'd1;
                            end
                            LO_LOAD:
                            begin
                                for (int i = 0; i <= x; i++)
                                    v[i] = mem[ireg[11:0] + i[11:0]];
                                ireg = ireg + x + 16'd1;
                            end
                            default: o.unknown_op = 1'b1;
                        endcase
                endcase
                cur_pc = pc_new;
                o.opcode_seen = word;
                n_exec++;
                if (o.draw) n_draw++;
                if (o.waiting_key) n_wait++;
                if (o.unknown_op) n_unknown++;
            end
        endcase
        o.pc_now = cur_pc;
        o.sound_on = sound_t != 0;
        return o;
    endfunction

    function automatic req_t mk_req(logic [1:0] f, logic [11:0] a, logic [7:0] d,
                                    logic [15:0] k, logic [7:0] rb);
        req_t r;
        r.func = f;
        r.addr = a;
        r.wdata = d;
        r.keys = k;
        r.rand_byte = rb;
        return r;
    endfunction

    function automatic void add_row(req_t r, bit typed, rsp_t e);
        stim_row_t row;
        row.r = r;
        row.typed = typed;
        row.e = e;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [15:0] rand_instr();
        logic [15:0] w;
        logic [7:0] lo_list [13];
        logic [3:0] alu_list [9];
        lo_list = '{LO_GETDT, LO_WKEY, LO_SETDT, LO_SETST, LO_ADDI, LO_FONT, LO_BCD,
                    LO_STORE, LO_LOAD, LO_GETDT, LO_SETST, LO_FONT, LO_LOAD};
        alu_list = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                     ALU_SBN, ALU_SHL};
        w = 16'($urandom);
        case (w[15:12])
            OPG_SYS:
                case ($urandom_range(0, 3))
                    0, 1: w[7:0] = LO_CLS;
                    2:    w[7:0] = LO_RET;
                    default: ;
                endcase
            OPG_ALU:
                if ($urandom_range(0, 9) != 0)
                    w[3:0] = alu_list[$urandom_range(0, 8)];
            OPG_KEY:
                if ($urandom_range(0, 9) != 0)
                    w[7:0] = $urandom_range(0, 1) ? LO_SKP : LO_SKNP;
            OPG_MISC:
                if ($urandom_range(0, 9) != 0)
                    w[7:0] = lo_list[$urandom_range(0, 12)];
            OPG_SER, OPG_SNER:
                if ($urandom_range(0, 1)) w[11:8] = w[7:4];
            default: ;
        endcase
        return w;
    endfunction

    // drive one transaction, predict it once accepted
    task automatic send(req_t r, bit typed, rsp_t e);
        rsp_t p;
        while ($urandom_range(0, 99) < tx_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        p = chip8_step(r);
        pending_results.push_back(typed ? e : p);
        sent++;
    endtask

    task automatic send_rand(req_t r);
        send(r, 1'b0, '0);
    endtask

    function automatic logic [15:0] rand_keys();
        return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
    endfunction

    // receiver stall, with one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_go && !hold_seen)
        begin
            hold_seen = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < rx_pct);
    end

    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", rsp);
            end
            else
            begin
                e = pending_results.pop_front();
                n_checked++;
                if (rsp.pc_now !== e.pc_now || rsp.opcode_seen !== e.opcode_seen
                    || rsp.draw !== e.draw || rsp.waiting_key !== e.waiting_key
                    || rsp.unknown_op !== e.unknown_op || rsp.sound_on !== e.sound_on
                    || rsp.pixels !== e.pixels)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", e, rsp);
                end
            end
        end
    end

    initial
    begin
        rsp_t z, e;
        req_t r;
        logic [15:0] w;
        int kind;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        mismatches = 0;
        sent = 0;
        tx_pct = 31;
        rx_pct = 46;
        hold_go = 1'b0;
        hold_seen = 1'b0;
        hold_left = 0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        z = '0;
        e = z;
        e.pc_now = 12'h200;
        add_row(mk_req(FN_READ, 12'h000, 8'h00, 16'h0000, 8'h00), 1'b1, e);
        add_row(mk_req(FN_TICK, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF), 1'b1, e);
        add_row(mk_req(FN_READ, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF), 1'b1, e);
        e.pc_now = 12'h202;
        e.unknown_op = 1'b1;
        add_row(mk_req(FN_EXEC, 12'h000, 8'h00, 16'h0000, 8'h00), 1'b1, e);
        e.unknown_op = 1'b0;
        add_row(mk_req(FN_WRITE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF), 1'b1, e);
        // V0 = FF, sound = V0, wait for key (none, then all), sprite with wrap, clear
        add_row(mk_req(FN_WRITE, 12'h202, 8'h60, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h203, 8'hFF, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_EXEC, 12'h000, 8'h00, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h204, 8'hF0, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h205, LO_SETST, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_EXEC, 12'h000, 8'h00, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_TICK, 12'h000, 8'h00, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h206, 8'hF1, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h207, LO_WKEY, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_EXEC, 12'h000, 8'h00, 16'h0000, 8'h0), 1'b0, z);
        add_row(mk_req(FN_EXEC, 12'h000, 8'h00, 16'hFFFF, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h208, 8'hD0, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h209, 8'h1F, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_EXEC, 12'h000, 8'h00, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_READ, 12'h0F8, 8'h00, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_READ, 12'h007, 8'h00, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h20A, 8'h00, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_WRITE, 12'h20B, LO_CLS, 16'h0, 8'h0), 1'b0, z);
        add_row(mk_req(FN_EXEC, 12'h000, 8'h00, 16'h0, 8'h0), 1'b0, z);
        foreach (dir_rows[i])
            send(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);

        while (sent < 850)
        begin
            if (sent >= 566)
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
            else if (sent >= 283)
            begin
                tx_pct = 46;
                rx_pct = 31;
            end
            if (sent >= 400 && !hold_go)
            begin
                tx_pct = 0;
                hold_go = 1'b1;
            end
            if (sent >= 480 && hold_go && hold_left == 0 && tx_pct == 0 && sent < 566)
                tx_pct = 46;
            if (sent >= 620 && sent < 625)
            begin
                req_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                w = rand_instr();
                send_rand(mk_req(FN_WRITE, cur_pc, w[15:8], rand_keys(), 8'($urandom)));
                send_rand(mk_req(FN_WRITE, cur_pc + 12'd1, w[7:0], rand_keys(),
                                 8'($urandom)));
                send_rand(mk_req(FN_EXEC, 12'($urandom), 8'($urandom), rand_keys(),
                                 8'($urandom)));
            end
            else
            begin
                r = mk_req(FN_WRITE, 12'($urandom), 8'($urandom), rand_keys(), 8'($urandom));
                if (kind < 78)
                    r.func = FN_WRITE;
                else if (kind < 86)
                    r.func = FN_EXEC;
                else if (kind < 93)
                    r.func = FN_TICK;
                else
                    r.func = FN_READ;
                send_rand(r);
            end
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d transactions, %0d instructions executed, %0d results checked",
                 sent, n_exec, n_checked);
        $display("draws %0d, key waits %0d, unknown opcodes %0d, mismatches %0d",
                 n_draw, n_wait, n_unknown, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
